// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files of the color set block.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/tcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsd_pkg
// Types, constants and helpers shared by the near-duplicate color filter.
// ----------------------------------------------------------------------------
package tcsd_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int MAX_RADIUS   = 16;
	localparam int FIELD_W      = 8;
	localparam int S_TDATA_W    = 3 * FIELD_W;
	localparam int M_TDATA_W    = 8;
	localparam int RADIUS_W     = 5;
	localparam int CFG_INDEX_W  = 2;
	localparam int CNT_W        = $clog2(MAX_RADIUS + 1);
	localparam int RAD_EXT_W    = (RADIUS_W > CNT_W) ? RADIUS_W : CNT_W;

	localparam int MAP_W        = 3 * CHANNEL_BITS;
	localparam int ROW_SEL_W    = 6;
	localparam int ROW_W        = 1 << ROW_SEL_W;
	localparam int ADDR_W       = MAP_W - ROW_SEL_W;
	localparam int MAP_DEPTH    = 1 << ADDR_W;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(4);

	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_RED   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_GREEN = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_BLUE  = CFG_INDEX_W'(2);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_DRAIN,
		ST_READ_OWN,
		ST_WRITE_OWN,
		ST_DONE
	} tcsd_state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic probe_step;
		logic rd_own;
		logic wr_own;
		logic out_load;
		logic out_added;
	} tcsd_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic zero_radius;
		logic probe_last;
		logic hit;
		logic out_free;
	} tcsd_stat_t;

	function automatic logic [CNT_W-1:0] clamp_radius(input logic [RADIUS_W-1:0] v);
		logic [RAD_EXT_W-1:0] ve;
		ve = RAD_EXT_W'(v);
		if (ve > RAD_EXT_W'(MAX_RADIUS)) begin
			return CNT_W'(MAX_RADIUS);
		end
		return CNT_W'(ve);
	endfunction

endpackage

// ===== src/tcsd_ram.sv =====
// ----------------------------------------------------------------------------
// tcsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/tcsd_datapath.sv =====
// ----------------------------------------------------------------------------
// tcsd_datapath
// Radius registers, probe counters, presence map and result register.
// ----------------------------------------------------------------------------
module tcsd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tcsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tcsd_pkg::RADIUS_W-1:0]       cfg_data,
	input  logic [tcsd_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [tcsd_pkg::M_TDATA_W-1:0]      m_tdata,
	input  tcsd_pkg::tcsd_cmd_t                 cmd,
	output tcsd_pkg::tcsd_stat_t                stat
);
	import tcsd_pkg::*;

	logic [RADIUS_W-1:0]     radius_red_q;
	logic [RADIUS_W-1:0]     radius_green_q;
	logic [RADIUS_W-1:0]     radius_blue_q;
	logic [CNT_W-1:0]        rr;
	logic [CNT_W-1:0]        rg;
	logic [CNT_W-1:0]        rb;
	logic [CHANNEL_BITS-1:0] red_q;
	logic [CHANNEL_BITS-1:0] green_q;
	logic [CHANNEL_BITS-1:0] blue_q;
	logic [CNT_W-1:0]        i_q;
	logic [CNT_W-1:0]        j_q;
	logic [CNT_W-1:0]        k_q;
	logic [2:0]              sign_q;
	logic                    i_last;
	logic                    j_last;
	logic                    k_last;
	logic [CHANNEL_BITS-1:0] pr;
	logic [CHANNEL_BITS-1:0] pg;
	logic [CHANNEL_BITS-1:0] pb;
	logic [MAP_W-1:0]        probe_color;
	logic [MAP_W-1:0]        own_color;
	logic                    probe_s1;
	logic [ROW_SEL_W-1:0]    bit_s1;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [ROW_W-1:0]        ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [ROW_W-1:0]        ram_rdata;
	logic                    out_valid_q;
	logic                    added_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_red_q   <= RADIUS_RESET;
			radius_green_q <= RADIUS_RESET;
			radius_blue_q  <= RADIUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS_RED:   radius_red_q   <= cfg_data;
				REG_RADIUS_GREEN: radius_green_q <= cfg_data;
				REG_RADIUS_BLUE:  radius_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rr = clamp_radius(radius_red_q);
	assign rg = clamp_radius(radius_green_q);
	assign rb = clamp_radius(radius_blue_q);

	assign i_last = (CNT_W'(i_q + 1'b1) == rr);
	assign j_last = (CNT_W'(j_q + 1'b1) == rg);
	assign k_last = (CNT_W'(k_q + 1'b1) == rb);

	// The sign bits run fastest, then blue, green and red offsets.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			red_q   <= s_tdata[CHANNEL_BITS-1:0];
			green_q <= s_tdata[FIELD_W +: CHANNEL_BITS];
			blue_q  <= s_tdata[2*FIELD_W +: CHANNEL_BITS];
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			sign_q  <= '0;
		end else if (cmd.probe_step) begin
			sign_q <= sign_q + 3'd1;
			if (sign_q == 3'd7) begin
				if (k_last) begin
					k_q <= '0;
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	assign pr = sign_q[2] ? red_q - CHANNEL_BITS'(i_q) : red_q + CHANNEL_BITS'(i_q);
	assign pg = sign_q[1] ? green_q - CHANNEL_BITS'(j_q) : green_q + CHANNEL_BITS'(j_q);
	assign pb = sign_q[0] ? blue_q - CHANNEL_BITS'(k_q) : blue_q + CHANNEL_BITS'(k_q);

	assign probe_color = {pr, pg, pb};
	assign own_color   = {red_q, green_q, blue_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1  <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			probe_s1 <= cmd.probe_step;
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		bit_s1 <= probe_color[ROW_SEL_W-1:0];
	end

	assign ram_raddr = cmd.rd_own ? own_color[MAP_W-1:ROW_SEL_W] : probe_color[MAP_W-1:ROW_SEL_W];
	assign ram_we    = cmd.clr_step | cmd.wr_own;
	assign ram_waddr = cmd.clr_step ? clr_cnt_q : own_color[MAP_W-1:ROW_SEL_W];
	assign ram_wdata = cmd.clr_step ? '0
		: (ram_rdata | (ROW_W'(1) << own_color[ROW_SEL_W-1:0]));

	tcsd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			added_q <= cmd.out_added;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(added_q);

	assign stat.clr_last    = &clr_cnt_q;
	assign stat.zero_radius = (rr == '0) | (rg == '0) | (rb == '0);
	assign stat.probe_last  = (sign_q == 3'd7) & k_last & j_last & i_last;
	assign stat.hit         = probe_s1 & ram_rdata[bit_s1];
	assign stat.out_free    = !out_valid_q | m_tready;

endmodule

// ===== src/tcsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcsd_ctrl
// Sequencer for map clearing, neighbor probing, insertion and result hand-off.
// ----------------------------------------------------------------------------
module tcsd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  tcsd_pkg::tcsd_stat_t stat,
	output tcsd_pkg::tcsd_cmd_t  cmd
);
	import tcsd_pkg::*;

	tcsd_state_t state_q;
	tcsd_state_t state_d;
	logic        added_q;
	logic        added_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			added_q <= 1'b0;
		end else begin
			state_q <= state_d;
			added_q <= added_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		added_d       = added_q;
		cmd           = '0;
		cmd.out_added = added_q;
		s_tready      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = stat.zero_radius ? ST_READ_OWN : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (stat.hit) begin
					added_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					cmd.probe_step = 1'b1;
					if (stat.probe_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (stat.hit) begin
					added_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					state_d = ST_READ_OWN;
				end
			end
			ST_READ_OWN: begin
				cmd.rd_own = 1'b1;
				state_d    = ST_WRITE_OWN;
			end
			ST_WRITE_OWN: begin
				cmd.wr_own = 1'b1;
				added_d    = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== src/tolerant_color_set_dedupe.sv =====
// ----------------------------------------------------------------------------
// tolerant_color_set_dedupe
// Near-duplicate RGB color filter over a one-bit-per-color presence map.
// ----------------------------------------------------------------------------
// After reset the presence map is cleared one 64-bit row per cycle, with
// s_tready low; radius writes are taken during that time. A color that is new
// runs through 8 * rr * rg * rb probes, where rr, rg and rb are the clamped
// radii (512 probes at the default radius of 4), and every probe takes one read
// of the single read port of the presence RAM. A hit, seen when the registered
// read of its probe returns, ends the search, and a zero radius skips straight
// to the insertion, which reads and then writes the row of the color. A finished
// word waits in the output register while the next color is accepted.
`include "assert_macros.svh"

module tolerant_color_set_dedupe (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tcsd_pkg::RADIUS_W-1:0]      cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tcsd_pkg::S_TDATA_W-1:0]     s_tdata,   // red, green, blue
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tcsd_pkg::M_TDATA_W-1:0]     m_tdata    // added, zero pad
);
	import tcsd_pkg::*;

	tcsd_cmd_t  cmd;
	tcsd_stat_t stat;

	tcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcsd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	`ASSERT_IMP(a_one_map_access, 1'b1, $onehot0({cmd.clr_step, cmd.probe_step, cmd.rd_own, cmd.wr_own}))
	`ASSERT_IMP(a_no_result_overwrite, cmd.out_load, stat.out_free)
	`ASSERT_NEXT(a_insert_follows_read, cmd.rd_own, cmd.wr_own)

endmodule

// ===== bench/tolerant_color_set_dedupe_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerant_color_set_dedupe_tb
// Self-checking bench for the near-duplicate color filter. Colors are streamed
// in under several radius settings and idle patterns. A behavioral presence
// map predicts the added flag of every color, and each returned word is
// checked in order against that prediction.
// ----------------------------------------------------------------------------
module tolerant_color_set_dedupe_tb;
	import tcsd_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [RADIUS_W-1:0]    cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;   // red, green, blue
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;   // added, zero pad

	bit                  color_seen[bit [23:0]];
	logic [RADIUS_W-1:0] span_red   = RADIUS_RESET;
	logic [RADIUS_W-1:0] span_green = RADIUS_RESET;
	logic [RADIUS_W-1:0] span_blue  = RADIUS_RESET;
	bit                  pending_added[$];
	logic [23:0]         offered[$];
	int                  errors         = 0;
	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;

	tolerant_color_set_dedupe dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit predict_added(input logic [7:0] r, g, b);
		int nr;
		int ng;
		int nb;
		logic [7:0] pr;
		logic [7:0] pg;
		logic [7:0] pb;
		nr = (span_red > MAX_RADIUS) ? MAX_RADIUS : span_red;
		ng = (span_green > MAX_RADIUS) ? MAX_RADIUS : span_green;
		nb = (span_blue > MAX_RADIUS) ? MAX_RADIUS : span_blue;
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < ng; j++) begin
				for (int k = 0; k < nb; k++) begin
					for (int s = 0; s < 8; s++) begin
						pr = s[2] ? 8'(r - i) : 8'(r + i);
						pg = s[1] ? 8'(g - j) : 8'(g + j);
						pb = s[0] ? 8'(b - k) : 8'(b + k);
						if (color_seen.exists({pr, pg, pb})) begin
							return 1'b0;
						end
					end
				end
			end
		end
		color_seen[{r, g, b}] = 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [7:0] jitter(input logic [7:0] c, input int span);
		return 8'(int'(c) + int'($urandom_range(2 * span + 2)) - span - 1);
	endfunction

	always @(posedge clk) begin
		bit want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_added.size() == 0) begin
				$error("added: no word expected, actual %0d", m_tdata[0]);
				errors++;
			end else begin
				want = pending_added.pop_front();
				if (m_tdata[0] !== want) begin
					$error("added: expected %0d, actual %0d", want, m_tdata[0]);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_color(input logic [7:0] r, g, b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_added.insert(pending_added.size(), predict_added(r, g, b));
		offered.insert(offered.size(), {r, g, b});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_added.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [RADIUS_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_RADIUS_RED:   span_red = val;
			REG_RADIUS_GREEN: span_green = val;
			REG_RADIUS_BLUE:  span_blue = val;
			default: ;
		endcase
	endtask

	task automatic set_radii(input logic [RADIUS_W-1:0] rr, rg, rb);
		cfg_write(REG_RADIUS_RED, rr);
		cfg_write(REG_RADIUS_GREEN, rg);
		cfg_write(REG_RADIUS_BLUE, rb);
		cfg_we <= 1'b0;
	endtask

	// Runs at the reset radius; the white color only finds black by wrapping.
	task automatic test_reset_radius();
		send_color(8'd0, 8'd0, 8'd0);
		send_color(8'd3, 8'd3, 8'd3);
		send_color(8'd4, 8'd0, 8'd0);
		send_color(8'd255, 8'd255, 8'd255);
		send_color(8'd252, 8'd0, 8'd0);
		send_color(8'd128, 8'd128, 8'd128);
	endtask

	// A zero radius on any channel inserts the color even when it is present.
	task automatic test_zero_radius();
		drain();
		set_radii(5'd0, 5'd4, 5'd4);
		send_color(8'd0, 8'd0, 8'd0);
		send_color(8'd0, 8'd0, 8'd0);
		drain();
		set_radii(5'd4, 5'd4, 5'd0);
		send_color(8'd128, 8'd128, 8'd128);
		drain();
		set_radii(5'd0, 5'd0, 5'd0);
		send_color(8'd77, 8'd77, 8'd77);
		send_color(8'd77, 8'd77, 8'd77);
	endtask

	// A radius of one probes the offered color alone.
	task automatic test_exact_match();
		drain();
		set_radii(5'd1, 5'd1, 5'd1);
		send_color(8'd77, 8'd77, 8'd77);
		send_color(8'd78, 8'd77, 8'd77);
		send_color(8'd77, 8'd77, 8'd76);
	endtask

	task automatic test_max_radius();
		drain();
		set_radii(5'd16, 5'd16, 5'd16);
		send_color(8'd200, 8'd60, 8'd160);
		send_color(8'd215, 8'd45, 8'd160);
	endtask

	// Radii above the maximum saturate, and a write to an unused index is dropped.
	task automatic test_saturation();
		drain();
		cfg_write(REG_RADIUS_RED, 5'd31);
		cfg_write(REG_UNUSED, 5'd1);
		cfg_write(REG_RADIUS_GREEN, 5'd17);
		cfg_write(REG_RADIUS_BLUE, 5'd31);
		cfg_we <= 1'b0;
		send_color(8'd232, 8'd60, 8'd160);
	endtask

	// Mostly colors close to earlier ones, straddling the search boundary,
	// mixed with repeats and colors drawn at random.
	task automatic test_random(input int count, input int sender_pct, input int receiver_pct,
			input logic [RADIUS_W-1:0] rr, rg, rb);
		logic [23:0] base;
		int pick;
		drain();
		set_radii(rr, rg, rb);
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (offered.size() == 0 || pick < 35) begin
				base = 24'($urandom);
			end else begin
				base = offered[$urandom_range(offered.size() - 1)];
				if (pick >= 45) begin
					base = {jitter(base[23:16], rr), jitter(base[15:8], rg),
						jitter(base[7:0], rb)};
				end
			end
			send_color(base[23:16], base[15:8], base[7:0]);
		end
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_radius();
		test_zero_radius();
		test_exact_match();
		test_max_radius();
		test_saturation();
		test_random(120, 0, 0, 5'd4, 5'd4, 5'd4);
		test_random(130, 47, 0, 5'd1, 5'd2, 5'd3);
		test_random(130, 0, 47, 5'd3, 5'd1, 5'd2);
		test_random(130, 17, 17, 5'd2, 5'd3, 5'd1);
		test_random(60, 17, 17, 5'd0, 5'd2, 5'd2);
		test_random(80, 47, 47, 5'd6, 5'd2, 5'd5);
		recv_stall_pct = 0;
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_added.size() == 0) begin
			$display("tolerant_color_set_dedupe: match");
		end else begin
			$display("tolerant_color_set_dedupe: mismatch");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tolerant_color_set_dedupe: mismatch");
		$finish;
	end

endmodule
